// ===== rtl/core/afb_pkg.sv =====
// ----------------------------------------------------------------------------
// afb_pkg
// Shared types and constants for the alpha fade / blink controller: request
// and mode codes, register indexes, field widths and the command and status
// groups that run between the controller and the datapath.
// ----------------------------------------------------------------------------
package afb_pkg;

   // Field widths
   localparam int ALPHA_W   = 17;   // Q1.16 alpha level
   localparam int STEP_W    = 18;   // signed per-tick step
   localparam int FRAME_W   = 16;
   localparam int DUR_W     = 16;
   localparam int CSR_IDX_W = 2;
   localparam int CSR_DAT_W = 17;

   // Step divider: one quotient bit per cycle
   localparam int DIV_STEPS = 16;
   localparam int DIVCNT_W  = 4;

   localparam logic [ALPHA_W-1:0] ALPHA_FULL = 17'h10000;

   // Request codes
   localparam logic [1:0] REQ_TICK     = 2'd0;
   localparam logic [1:0] REQ_FADE_IN  = 2'd1;
   localparam logic [1:0] REQ_FADE_OUT = 2'd2;
   localparam logic [1:0] REQ_BLINK    = 2'd3;

   // Mode codes
   localparam logic [1:0] MODE_IDLE     = 2'd0;
   localparam logic [1:0] MODE_FADE_IN  = 2'd1;
   localparam logic [1:0] MODE_FADE_OUT = 2'd2;
   localparam logic [1:0] MODE_BLINK    = 2'd3;

   // Register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_FRAME_TIME = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_MIN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_BLINK_MAX  = 2'd2;

   // Controller to datapath
   typedef struct packed {
      logic load_item;   // latch the accepted request
      logic div_start;   // seed the step divider
      logic div_step;    // one divider iteration
      logic apply;       // update state and load the response
   } afb_cmd_type;

   // Datapath to controller
   typedef struct packed {
      logic need_div;    // request needs a computed step magnitude
      logic div_last;    // final divider iteration in progress
   } afb_status_type;

endpackage

// ===== rtl/core/afb_ctrl.sv =====
// ----------------------------------------------------------------------------
// afb_ctrl
// Sequencer for the alpha controller: takes one request at a time, runs the
// step divider when a command needs it, and owns the response valid flag.
// ----------------------------------------------------------------------------
module afb_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   output logic                    rsp_valid,
   input  logic                    rsp_ready,
   output afb_pkg::afb_cmd_type    cmd,
   input  afb_pkg::afb_status_type status
);

   localparam logic [1:0] ST_IDLE  = 2'd0;
   localparam logic [1:0] ST_EVAL  = 2'd1;
   localparam logic [1:0] ST_DIV   = 2'd2;
   localparam logic [1:0] ST_APPLY = 2'd3;

   logic [1:0] state_ff;
   logic [1:0] state_in;
   logic       rsp_valid_ff;
   logic       rsp_valid_in;
   logic       ready_int;
   logic       accept;

   // Take a request only when idle and the response slot is free or draining
   assign ready_int = !reset && (state_ff == ST_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && ready_int;
   assign req_ready = ready_int;
   assign rsp_valid = rsp_valid_ff;

   // Next state and commands
   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cmd.load_item = 1'b1;
               state_in      = ST_EVAL;
            end
         end
         ST_EVAL: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = ST_DIV;
            end else begin
               cmd.apply = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         ST_DIV: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_APPLY;
            end
         end
         ST_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = ST_IDLE;
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Response valid: set on apply, cleared when the response is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      if (cmd.apply) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/core/afb_dp.sv =====
// ----------------------------------------------------------------------------
// afb_dp
// Datapath for the alpha controller: config registers, alpha/step/mode state,
// a bit-serial step divider and the registered response payload.
// ----------------------------------------------------------------------------
module afb_dp (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 csr_we,
   input  logic [afb_pkg::CSR_IDX_W-1:0]        csr_index,
   input  logic [afb_pkg::CSR_DAT_W-1:0]        csr_wdata,
   input  logic [1:0]                           req_type,
   input  logic [afb_pkg::DUR_W-1:0]            req_duration,
   output logic [7:0]                           rsp_alpha_byte,
   output logic [1:0]                           rsp_mode,
   input  afb_pkg::afb_cmd_type                 cmd,
   output afb_pkg::afb_status_type              status
);

   localparam logic signed [18:0] SUM_FULL = 19'sh10000;

   // Config registers
   logic [afb_pkg::FRAME_W-1:0] frame_time_ff;
   logic [afb_pkg::ALPHA_W-1:0] blink_min_ff;
   logic [afb_pkg::ALPHA_W-1:0] blink_max_ff;

   // Latched request
   logic [1:0]                  item_type_ff;
   logic [afb_pkg::DUR_W-1:0]   item_dur_ff;

   // Architectural state
   logic [1:0]                  mode_ff;
   logic [1:0]                  mode_in;
   logic [afb_pkg::ALPHA_W-1:0] alpha_ff;
   logic [afb_pkg::ALPHA_W-1:0] alpha_in;
   logic [afb_pkg::STEP_W-1:0]  step_ff;
   logic [afb_pkg::STEP_W-1:0]  step_in;

   // Divider
   logic [afb_pkg::DUR_W-1:0]    rem_ff;
   logic [afb_pkg::DUR_W-1:0]    rem_in;
   logic [afb_pkg::DUR_W-1:0]    quo_ff;
   logic [afb_pkg::DUR_W-1:0]    quo_in;
   logic [afb_pkg::DIVCNT_W-1:0] cnt_ff;
   logic [afb_pkg::DIVCNT_W-1:0] cnt_in;
   logic [afb_pkg::DUR_W:0]      div_trial;
   logic                         div_ge;

   // Response payload
   logic [7:0] rsp_alpha_byte_ff;
   logic [1:0] rsp_mode_ff;

   // Apply helpers
   logic                        dur_zero;
   logic                        mag_sat;
   logic [afb_pkg::ALPHA_W-1:0] mag;
   logic [afb_pkg::STEP_W-1:0]  mag_pos;
   logic [afb_pkg::STEP_W-1:0]  mag_neg;
   logic signed [18:0]          tick_sum;
   logic                        step_is_pos;
   logic [24:0]                 scaled_prod;
   logic [8:0]                  scaled;

   // Config writes
   always_ff @(posedge clock) begin
      if (reset) begin
         frame_time_ff <= 16'd1;
         blink_min_ff  <= '0;
         blink_max_ff  <= afb_pkg::ALPHA_FULL;
      end else if (csr_we) begin
         case (csr_index)
            afb_pkg::CSR_FRAME_TIME: frame_time_ff <= csr_wdata[afb_pkg::FRAME_W-1:0];
            afb_pkg::CSR_BLINK_MIN:  blink_min_ff  <= csr_wdata;
            afb_pkg::CSR_BLINK_MAX:  blink_max_ff  <= csr_wdata;
            default: begin
            end
         endcase
      end
   end

   // Request latch
   always_ff @(posedge clock) begin
      if (cmd.load_item) begin
         item_type_ff <= req_type;
         item_dur_ff  <= req_duration;
      end
   end

   // Step magnitude saturates when duration is zero or frame_time >= duration;
   // otherwise the quotient fits 16 bits and the divider produces it
   assign dur_zero        = (item_dur_ff == '0);
   assign mag_sat         = dur_zero || (frame_time_ff >= item_dur_ff);
   assign status.need_div = (item_type_ff != afb_pkg::REQ_TICK) && !mag_sat;
   assign status.div_last = (cnt_ff == afb_pkg::DIVCNT_W'(afb_pkg::DIV_STEPS - 1));

   // Restoring divider: (frame_time << 16) / duration, one bit per cycle
   assign div_trial = {rem_ff, 1'b0};
   assign div_ge    = (div_trial >= {1'b0, item_dur_ff});

   always_comb begin
      rem_in = rem_ff;
      quo_in = quo_ff;
      cnt_in = cnt_ff;
      if (cmd.div_start) begin
         rem_in = frame_time_ff;
         quo_in = '0;
         cnt_in = '0;
      end else if (cmd.div_step) begin
         rem_in = div_ge ? afb_pkg::DUR_W'(div_trial - {1'b0, item_dur_ff})
                         : div_trial[afb_pkg::DUR_W-1:0];
         quo_in = {quo_ff[afb_pkg::DUR_W-2:0], div_ge};
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      rem_ff <= rem_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign mag      = mag_sat ? afb_pkg::ALPHA_FULL : {1'b0, quo_ff};
   assign mag_pos  = {1'b0, mag};
   assign mag_neg  = -mag_pos;
   assign tick_sum = $signed({2'b00, alpha_ff}) + $signed({step_ff[afb_pkg::STEP_W-1], step_ff});
   assign step_is_pos = !step_ff[afb_pkg::STEP_W-1] && (step_ff != '0);

   // State update for the current request
   always_comb begin
      mode_in  = mode_ff;
      alpha_in = alpha_ff;
      step_in  = step_ff;
      case (item_type_ff)
         afb_pkg::REQ_TICK: begin
            case (mode_ff)
               afb_pkg::MODE_FADE_IN: begin
                  if (tick_sum >= SUM_FULL) begin
                     alpha_in = afb_pkg::ALPHA_FULL;
                     mode_in  = afb_pkg::MODE_IDLE;
                  end else begin
                     alpha_in = tick_sum[afb_pkg::ALPHA_W-1:0];
                  end
               end
               afb_pkg::MODE_FADE_OUT: begin
                  if (tick_sum <= 19'sd0) begin
                     alpha_in = '0;
                     mode_in  = afb_pkg::MODE_IDLE;
                  end else begin
                     alpha_in = tick_sum[afb_pkg::ALPHA_W-1:0];
                  end
               end
               afb_pkg::MODE_BLINK: begin
                  // upper bound is checked first; bounce reverses the step
                  if (tick_sum >= $signed({2'b00, blink_max_ff})) begin
                     alpha_in = blink_max_ff;
                     step_in  = -step_ff;
                  end else if (tick_sum <= $signed({2'b00, blink_min_ff})) begin
                     alpha_in = blink_min_ff;
                     step_in  = -step_ff;
                  end else begin
                     alpha_in = tick_sum[afb_pkg::ALPHA_W-1:0];
                  end
               end
               default: begin
               end
            endcase
         end
         afb_pkg::REQ_FADE_IN: begin
            if (alpha_ff == afb_pkg::ALPHA_FULL) begin
               mode_in = afb_pkg::MODE_IDLE;
            end else if (dur_zero) begin
               mode_in  = afb_pkg::MODE_IDLE;
               alpha_in = afb_pkg::ALPHA_FULL;
            end else begin
               alpha_in = '0;
               mode_in  = afb_pkg::MODE_FADE_IN;
               step_in  = mag_pos;
            end
         end
         afb_pkg::REQ_FADE_OUT: begin
            if (dur_zero) begin
               mode_in  = afb_pkg::MODE_IDLE;
               alpha_in = '0;
            end else begin
               alpha_in = afb_pkg::ALPHA_FULL;
               mode_in  = afb_pkg::MODE_FADE_OUT;
               step_in  = mag_neg;
            end
         end
         afb_pkg::REQ_BLINK: begin
            // ignored while fading
            if ((mode_ff == afb_pkg::MODE_IDLE) || (mode_ff == afb_pkg::MODE_BLINK)) begin
               mode_in = afb_pkg::MODE_BLINK;
               step_in = step_is_pos ? mag_pos : mag_neg;
            end
         end
         default: begin
         end
      endcase
   end

   // 255 * alpha >> 16, saturated at 255
   assign scaled_prod = {alpha_in, 8'b0} - {8'b0, alpha_in};
   assign scaled      = scaled_prod[24:16];

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff  <= afb_pkg::MODE_IDLE;
         alpha_ff <= '0;
         step_ff  <= '0;
      end else if (cmd.apply) begin
         mode_ff  <= mode_in;
         alpha_ff <= alpha_in;
         step_ff  <= step_in;
      end
   end

   // Response payload
   always_ff @(posedge clock) begin
      if (cmd.apply) begin
         rsp_alpha_byte_ff <= scaled[8] ? 8'hFF : scaled[7:0];
         rsp_mode_ff       <= mode_in;
      end
   end

   assign rsp_alpha_byte = rsp_alpha_byte_ff;
   assign rsp_mode       = rsp_mode_ff;

endmodule

// ===== rtl/core/alpha_fade_blink_controller.sv =====
// Sequence: a tick or a saturating command is accepted in idle and applied in the
// evaluate state; a command whose step needs the divider runs the 16-iteration
// serial step divider before its apply state. The response is registered on apply,
// and one request is in flight at a time: the next is taken only back in idle.
// Reset (synchronous, active high) sets idle mode, alpha 0, step 0 and the
// register defaults, and empties the response slot.
// ----------------------------------------------------------------------------
// alpha_fade_blink_controller
// Q1.16 alpha fade / blink controller: ticks advance the level, commands start
// fades or blinks; each request returns the level as a byte and the mode.
// ----------------------------------------------------------------------------
module alpha_fade_blink_controller (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           csr_we,
   input  logic [afb_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [afb_pkg::CSR_DAT_W-1:0]  csr_wdata,
   input  logic                           req_valid,
   output logic                           req_ready,
   input  logic [1:0]                     req_type,
   input  logic [afb_pkg::DUR_W-1:0]      req_duration,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [7:0]                     rsp_alpha_byte,
   output logic [1:0]                     rsp_mode
);

   afb_pkg::afb_cmd_type    cmd;
   afb_pkg::afb_status_type status;

   // Sequencer
   afb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   // Datapath
   afb_dp u_dp (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_type       (req_type),
      .req_duration   (req_duration),
      .rsp_alpha_byte (rsp_alpha_byte),
      .rsp_mode       (rsp_mode),
      .cmd            (cmd),
      .status         (status)
   );

endmodule

// ===== rtl/core/afb_checker.sv =====
// ----------------------------------------------------------------------------
// afb_checker
// Port-level checks for the alpha controller, bound to the top level.
// ----------------------------------------------------------------------------
module afb_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [7:0] rsp_alpha_byte,
   input logic [1:0] rsp_mode
);

   // Reset empties the response slot
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("response valid after reset");

   // A stalled response holds its payload
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_alpha_byte) && $stable(rsp_mode))
      else $error("stalled response changed");

   // One request in flight: no back-to-back acceptance
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("request accepted while busy");

   // A request is only taken when the response slot will be free
   a_slot_free: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("response slot busy after acceptance");

endmodule

bind alpha_fade_blink_controller afb_checker u_afb_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_valid),
   .req_ready      (req_ready),
   .rsp_valid      (rsp_valid),
   .rsp_ready      (rsp_ready),
   .rsp_alpha_byte (rsp_alpha_byte),
   .rsp_mode       (rsp_mode)
);

// ===== dv/alpha_fade_blink_controller_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// alpha_fade_blink_controller_tb
// Drives ticks, fades and blinks through the request channel under several
// register settings and checks every response against an in-bench model of the
// alpha level, step and mode, or a typed-in expectation for pinned rows. A short
// directed table runs first, then random command-plus-ticks runs with random stalls.
// ----------------------------------------------------------------------------
module alpha_fade_blink_controller_tb;

   localparam int HALF_PERIOD = 4;
   localparam int RESET_CYCLES = 7;
   localparam int STALL_LIMIT = 1000;
   localparam int PHASE_ITEMS = 66;
   localparam int DRAIN_CYCLES = 25;
   localparam logic [afb_pkg::CSR_IDX_W-1:0] CSR_SPARE = 2'd3;   // unmapped index

   typedef struct packed {
      logic [7:0] lvl;
      logic [1:0] md;
   } alpha_rsp_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic [15:0] dur;
      logic        pinned;   // expected response typed in below
      logic [7:0]  lvl;
      logic [1:0]  md;
   } dir_row_type;

   // DUT ports
   logic                          clock = 1'b0;
   logic                          reset = 1'b1;
   logic                          csr_we = 1'b0;
   logic [afb_pkg::CSR_IDX_W-1:0] csr_index = '0;
   logic [afb_pkg::CSR_DAT_W-1:0] csr_wdata = '0;
   logic                          req_valid = 1'b0;
   logic                          req_ready;
   logic [1:0]                    req_type = afb_pkg::REQ_TICK;
   logic [afb_pkg::DUR_W-1:0]     req_duration = '0;
   logic                          rsp_valid;
   logic                          rsp_ready = 1'b0;
   logic [7:0]                    rsp_alpha_byte;
   logic [1:0]                    rsp_mode;

   // Typed-in expectation travels with the request
   logic       req_pinned = 1'b0;
   logic [7:0] pin_lvl = '0;
   logic [1:0] pin_mode = afb_pkg::MODE_IDLE;

   // Model state and register copies
   logic [1:0]         mode_now = afb_pkg::MODE_IDLE;
   logic [16:0]        alpha_now = '0;
   logic signed [17:0] step_now = '0;
   logic [15:0]        cfg_frame = 16'd1;
   logic [16:0]        cfg_min = '0;
   logic [16:0]        cfg_max = afb_pkg::ALPHA_FULL;

   alpha_rsp_type pending_rsp[$];
   int            err_count = 0;
   int            quiet_cycles = 0;
   int            rsp_hold = 0;
   bit            req_gaps_on = 1'b0;
   bit            rsp_gaps_on = 1'b0;
   logic [15:0]   phase_frame = 16'd1;

   alpha_fade_blink_controller u_dut (
      .clock          (clock),
      .reset          (reset),
      .csr_we         (csr_we),
      .csr_index      (csr_index),
      .csr_wdata      (csr_wdata),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_type       (req_type),
      .req_duration   (req_duration),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_alpha_byte (rsp_alpha_byte),
      .rsp_mode       (rsp_mode)
   );

   always begin
      #HALF_PERIOD clock = 1'b1;
      #HALF_PERIOD clock = 1'b0;
   end

   // Step magnitude: frame_time * 65536 / duration, saturated at full
   function automatic int fade_rate(input logic [15:0] dur);
      logic [31:0] q;
      if (dur == 16'd0)
         return int'(afb_pkg::ALPHA_FULL);
      q = {cfg_frame, 16'h0000} / {16'h0000, dur};
      if (q > 32'(afb_pkg::ALPHA_FULL))
         q = 32'(afb_pkg::ALPHA_FULL);
      return int'(q);
   endfunction

   // Advance the model by one request and return the expected response
   task automatic advance_alpha(input logic [1:0] kind, input logic [15:0] dur,
                                output alpha_rsp_type res);
      int          lvl_i;
      int          stp_i;
      int          nxt;
      int          bmin;
      int          bmax;
      int          mag;
      logic [31:0] scaled;
      lvl_i = alpha_now;
      stp_i = step_now;
      bmin = cfg_min;
      bmax = cfg_max;
      nxt = lvl_i + stp_i;
      case (kind)
         afb_pkg::REQ_TICK: begin
            case (mode_now)
               afb_pkg::MODE_FADE_IN: begin
                  if (nxt >= int'(afb_pkg::ALPHA_FULL)) begin
                     alpha_now = afb_pkg::ALPHA_FULL;
                     mode_now = afb_pkg::MODE_IDLE;
                  end else begin
                     alpha_now = nxt[16:0];
                  end
               end
               afb_pkg::MODE_FADE_OUT: begin
                  if (nxt <= 0) begin
                     alpha_now = '0;
                     mode_now = afb_pkg::MODE_IDLE;
                  end else begin
                     alpha_now = nxt[16:0];
                  end
               end
               afb_pkg::MODE_BLINK: begin
                  // upper bound is tested first
                  if (nxt >= bmax) begin
                     alpha_now = cfg_max;
                     step_now = -step_now;
                  end else if (nxt <= bmin) begin
                     alpha_now = cfg_min;
                     step_now = -step_now;
                  end else begin
                     alpha_now = nxt[16:0];
                  end
               end
               default: ;
            endcase
         end
         afb_pkg::REQ_FADE_IN: begin
            if (alpha_now == afb_pkg::ALPHA_FULL) begin
               mode_now = afb_pkg::MODE_IDLE;
            end else if (dur == 16'd0) begin
               mode_now = afb_pkg::MODE_IDLE;
               alpha_now = afb_pkg::ALPHA_FULL;
            end else begin
               alpha_now = '0;
               mode_now = afb_pkg::MODE_FADE_IN;
               step_now = 18'(fade_rate(dur));
            end
         end
         afb_pkg::REQ_FADE_OUT: begin
            alpha_now = afb_pkg::ALPHA_FULL;
            if (dur == 16'd0) begin
               mode_now = afb_pkg::MODE_IDLE;
               alpha_now = '0;
            end else begin
               mode_now = afb_pkg::MODE_FADE_OUT;
               step_now = 18'(-fade_rate(dur));
            end
         end
         default: begin
            // blink only starts from idle or restarts a blink; keeps step sign
            if (mode_now == afb_pkg::MODE_IDLE || mode_now == afb_pkg::MODE_BLINK) begin
               mag = fade_rate(dur);
               mode_now = afb_pkg::MODE_BLINK;
               step_now = (step_now > 0) ? 18'(mag) : 18'(-mag);
            end
         end
      endcase
      scaled = ({15'h0, alpha_now} * 32'd255) >> 16;
      if (scaled > 32'd255)
         scaled = 32'd255;
      res.lvl = scaled[7:0];
      res.md = mode_now;
   endtask

   // Monitor: register writes, response checks, then request predictions
   always @(posedge clock) begin
      alpha_rsp_type want;
      alpha_rsp_type got;
      if (!reset) begin
         if (csr_we) begin
            case (csr_index)
               afb_pkg::CSR_FRAME_TIME: cfg_frame = csr_wdata[15:0];
               afb_pkg::CSR_BLINK_MIN:  cfg_min = csr_wdata;
               afb_pkg::CSR_BLINK_MAX:  cfg_max = csr_wdata;
               default: ;
            endcase
         end
         if (rsp_valid && rsp_ready) begin
            if (pending_rsp.size() == 0) begin
               $error("unexpected response: alpha_byte=%0d mode=%0d",
                      rsp_alpha_byte, rsp_mode);
               err_count++;
            end else begin
               want = pending_rsp.pop_front();
               if (rsp_alpha_byte !== want.lvl) begin
                  $error("alpha_byte: expected %0d, got %0d", want.lvl, rsp_alpha_byte);
                  err_count++;
               end
               if (rsp_mode !== want.md) begin
                  $error("mode: expected %0d, got %0d", want.md, rsp_mode);
                  err_count++;
               end
            end
         end
         if (req_valid && req_ready) begin
            advance_alpha(req_type, req_duration, got);
            if (req_pinned) begin
               got.lvl = pin_lvl;
               got.md = pin_mode;
            end
            pending_rsp.push_back(got);
         end
      end
   end

   // Response side back-pressure in short random bursts
   always @(posedge clock) begin
      if (rsp_hold > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold--;
      end else if (rsp_gaps_on && $urandom_range(0, 5) == 0) begin
         rsp_ready <= 1'b0;
         rsp_hold = $urandom_range(1, 3) - 1;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   // Watchdog on cycles without any handshake
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready) || csr_we)
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("alpha_fade_blink_controller_tb: errors");
         $finish;
      end
   end

   // Present one request and hold it until accepted
   task automatic send_request(input logic [1:0] kind, input logic [15:0] dur,
                               input logic pinned, input logic [7:0] lvl,
                               input logic [1:0] md);
      if (req_gaps_on && $urandom_range(0, 4) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_type <= kind;
      req_duration <= dur;
      req_pinned <= pinned;
      pin_lvl <= lvl;
      pin_mode <= md;
      do @(posedge clock); while (!req_ready);
   endtask

   // Hold requests until every response is back, then let the block settle;
   // the queue is checked only after the last accepted request has been pushed into it
   task automatic drain_responses();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_settings(input logic [15:0] ft, input logic [16:0] mn,
                                 input logic [16:0] mx, input bit spare);
      logic junk;
      junk = 1'($urandom_range(0, 1));   // bit 16 is unused for frame_time
      csr_we <= 1'b1;
      csr_index <= afb_pkg::CSR_FRAME_TIME;
      csr_wdata <= {junk, ft};
      @(posedge clock);
      csr_index <= afb_pkg::CSR_BLINK_MIN;
      csr_wdata <= mn;
      @(posedge clock);
      csr_index <= afb_pkg::CSR_BLINK_MAX;
      csr_wdata <= mx;
      @(posedge clock);
      if (spare) begin
         csr_index <= CSR_SPARE;
         csr_wdata <= 17'($urandom_range(0, 17'h1FFFF));
         @(posedge clock);
      end
      csr_we <= 1'b0;
      phase_frame = ft;
   endtask

   // Durations mostly a few frames long so fades and blinks finish
   function automatic logic [15:0] pick_duration();
      int          r;
      logic [31:0] d;
      r = $urandom_range(0, 99);
      if (r < 6)
         return 16'd0;
      if (r < 14)
         return 16'($urandom_range(0, 16'hFFFF));
      if (phase_frame == 16'd0)
         d = $urandom_range(1, 64);
      else
         d = phase_frame * $urandom_range(1, 24);
      if (d > 32'hFFFF)
         d = 32'hFFFF;
      return d[15:0];
   endfunction

   // Random command-plus-ticks sequences, with some stray requests mixed in
   task automatic run_random(input int n_items);
      int         sent;
      int         n_ticks;
      logic [1:0] cmd;
      sent = 0;
      while (sent < n_items) begin
         if ($urandom_range(0, 39) == 0)
            drain_responses();
         if ($urandom_range(0, 99) < 10) begin
            send_request(2'($urandom_range(0, 3)), 16'($urandom_range(0, 16'hFFFF)),
                         1'b0, '0, afb_pkg::MODE_IDLE);
            sent++;
         end else begin
            cmd = 2'($urandom_range(1, 3));
            send_request(cmd, pick_duration(), 1'b0, '0, afb_pkg::MODE_IDLE);
            sent++;
            n_ticks = (cmd == afb_pkg::REQ_BLINK) ? $urandom_range(4, 40)
                                                  : $urandom_range(0, 26);
            for (int i = 0; i < n_ticks && sent < n_items; i++) begin
               send_request(afb_pkg::REQ_TICK, 16'($urandom_range(0, 16'hFFFF)), 1'b0,
                            '0, afb_pkg::MODE_IDLE);
               sent++;
            end
         end
      end
   endtask

   // Directed requests from reset defaults
   dir_row_type dir_rows[25];

   initial begin
      dir_rows = '{
         '{afb_pkg::REQ_TICK,     16'd0,    1'b1, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_FADE_IN,  16'd0,    1'b1, 8'd255, afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_FADE_IN,  16'd5,    1'b1, 8'd255, afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_FADE_OUT, 16'd0,    1'b1, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_FADE_IN,  16'hFFFF, 1'b1, 8'd0,   afb_pkg::MODE_FADE_IN},
         '{afb_pkg::REQ_TICK,     16'hFFFF, 1'b0, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_BLINK,    16'd1,    1'b0, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_FADE_IN,  16'd1,    1'b1, 8'd0,   afb_pkg::MODE_FADE_IN},
         '{afb_pkg::REQ_TICK,     16'd0,    1'b1, 8'd255, afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_FADE_OUT, 16'd2,    1'b1, 8'd255, afb_pkg::MODE_FADE_OUT},
         '{afb_pkg::REQ_TICK,     16'd0,    1'b0, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_TICK,     16'd0,    1'b1, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_BLINK,    16'd4,    1'b1, 8'd0,   afb_pkg::MODE_BLINK},
         '{afb_pkg::REQ_TICK,     16'd0,    1'b0, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_TICK,     16'd0,    1'b0, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_TICK,     16'd0,    1'b0, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_TICK,     16'd0,    1'b0, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_TICK,     16'd0,    1'b0, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_TICK,     16'd0,    1'b0, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_BLINK,    16'd0,    1'b0, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_TICK,     16'd0,    1'b0, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_BLINK,    16'hFFFF, 1'b0, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_TICK,     16'd0,    1'b0, 8'd0,   afb_pkg::MODE_IDLE},
         '{afb_pkg::REQ_FADE_OUT, 16'hFFFF, 1'b1, 8'd255, afb_pkg::MODE_FADE_OUT},
         '{afb_pkg::REQ_FADE_IN,  16'd3,    1'b1, 8'd255, afb_pkg::MODE_IDLE}
      };

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed part with the idle/stall machinery already running
      req_gaps_on = 1'b1;
      rsp_gaps_on = 1'b1;
      foreach (dir_rows[i])
         send_request(dir_rows[i].kind, dir_rows[i].dur, dir_rows[i].pinned,
                      dir_rows[i].lvl, dir_rows[i].md);

      // random phases, one register setting each
      for (int p = 0; p < 8; p++) begin
         drain_responses();
         req_gaps_on = (p % 3) != 2;
         rsp_gaps_on = (p % 4) != 3;
         case (p)
            0: write_settings(16'd1, 17'd0, afb_pkg::ALPHA_FULL, 1'b0);
            1: write_settings(16'hFFFF, 17'd0, afb_pkg::ALPHA_FULL, 1'b0);
            2: write_settings(16'd0, 17'd1000, 17'd60000, 1'b0);   // fades stand still
            3: write_settings(16'($urandom_range(1, 300)), 17'($urandom_range(0, 30000)),
                              17'($urandom_range(35000, 65536)), 1'b1);
            4: write_settings(16'($urandom_range(1, 200)), afb_pkg::ALPHA_FULL, 17'd0,
                              1'b0);
            5: write_settings(16'd7, 17'd20000, 17'h1FFFF, 1'b0);  // max above full
            6: write_settings(16'($urandom_range(1, 16'hFFFF)),
                              17'($urandom_range(0, 17'h1FFFF)),
                              17'($urandom_range(0, 17'h1FFFF)), 1'b0);
            default: begin
               // last stretch runs without idling on either side
               req_gaps_on = 1'b0;
               rsp_gaps_on = 1'b0;
               write_settings(16'd3, 17'd0, afb_pkg::ALPHA_FULL, 1'b0);
            end
         endcase
         run_random(PHASE_ITEMS);
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_rsp.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (err_count == 0)
         $display("alpha_fade_blink_controller_tb: clean");
      else
         $display("alpha_fade_blink_controller_tb: errors");
      $finish;
   end

endmodule
